FILE: sv/fjg_pkg.sv
// fjg_pkg: shared types and constants for the feeder jam guard with heat lock.
// No dependencies; used by fjg_step, the top level and the checker.
package fjg_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_MARGIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESUME_HEAT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TOLERANCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_TIMEOUT_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JAMS_BEFORE_STOP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_SPEED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MS       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MS          = 3'd7;

  localparam logic [3:0] JAM_COUNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_BLOCKED,
    MODE_REVERSING,
    MODE_STOPPED
  } fjg_mode_t;

  typedef struct packed {
    logic [15:0]        lock_margin;
    logic [15:0]        resume_heat;
    logic [14:0]        speed_tolerance;
    logic [15:0]        jam_timeout_ms;
    logic [3:0]         jams_before_stop;
    logic signed [15:0] backoff_speed;
    logic [15:0]        reverse_ms;
    logic [15:0]        stop_ms;
  } fjg_cfg_t;

  typedef struct packed {
    logic               heat_locked;
    fjg_mode_t          mode;
    logic               stall_timing;
    logic [31:0]        stall_start;
    logic [3:0]         jam_count;
    logic [31:0]        phase_start;
    logic signed [15:0] last_trigger_command;
    logic signed [15:0] last_friction_command;
  } fjg_state_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [15:0]        heat;
    logic [15:0]        heat_limit;
    logic signed [15:0] friction_target;
    logic signed [15:0] trigger_target;
    logic signed [15:0] trigger_measured;
  } fjg_item_t;

  typedef struct packed {
    logic               command_sent;
    logic signed [15:0] friction_command;
    logic signed [15:0] trigger_command;
    logic [1:0]         jam_mode;
    logic               fire_inhibited;
  } fjg_result_t;

endpackage

FILE: sv/fjg_step.sv
// fjg_step: one control step of the heat lock and jam machine, combinational.
// Depends on fjg_pkg for the config, state, item and result types.
module fjg_step (
  input  fjg_pkg::fjg_cfg_t    cfg,
  input  fjg_pkg::fjg_state_t  state,
  input  fjg_pkg::fjg_item_t   item,
  output fjg_pkg::fjg_state_t  state_nxt,
  output fjg_pkg::fjg_result_t result
);

  logic [16:0]        thr_diff;
  logic [15:0]        thr;
  logic               locked;
  logic signed [15:0] trig;
  logic signed [17:0] trig_x;
  logic signed [17:0] meas_x;
  logic signed [17:0] stall_lvl;
  logic               stall;
  logic [31:0]        stall_base;
  logic [31:0]        stall_elapsed;
  logic [31:0]        phase_elapsed;
  logic [3:0]         cnt_inc;
  logic               sent;
  logic signed [15:0] cmd_trig;

  // lock point: heat_limit - lock_margin, floored at zero
  assign thr_diff = {1'b0, item.heat_limit} - {1'b0, cfg.lock_margin};
  assign thr = thr_diff[16] ? 16'd0 : thr_diff[15:0];
  assign locked = state.heat_locked ? !(item.heat < cfg.resume_heat) : (item.heat >= thr);
  assign trig = locked ? 16'sd0 : item.trigger_target;

  assign trig_x = {{2{trig[15]}}, trig};
  assign meas_x = {{2{item.trigger_measured[15]}}, item.trigger_measured};
  assign stall_lvl = trig_x - $signed({3'b000, cfg.speed_tolerance});
  assign stall = (trig > 16'sd0) && (meas_x < stall_lvl);

  assign stall_base = state.stall_timing ? state.stall_start : item.now_ms;
  assign stall_elapsed = item.now_ms - stall_base;
  assign phase_elapsed = item.now_ms - state.phase_start;
  assign cnt_inc = (state.jam_count < fjg_pkg::JAM_COUNT_MAX) ?
                   state.jam_count + 4'd1 : state.jam_count;

  always_comb begin
    state_nxt = state;
    state_nxt.heat_locked = locked;
    sent = 1'b0;
    cmd_trig = 16'sd0;
    case (state.mode)
      fjg_pkg::MODE_NORMAL: begin
        sent = 1'b1;
        cmd_trig = trig;
        if (stall) begin
          state_nxt.stall_start = stall_base;
          if (stall_elapsed >= {16'd0, cfg.jam_timeout_ms}) begin
            state_nxt.mode = fjg_pkg::MODE_BLOCKED;
            state_nxt.stall_timing = 1'b0;
          end else begin
            state_nxt.stall_timing = 1'b1;
          end
        end else begin
          state_nxt.stall_timing = 1'b0;
        end
      end
      fjg_pkg::MODE_BLOCKED: begin
        sent = 1'b1;
        state_nxt.phase_start = item.now_ms;
        if (cnt_inc >= cfg.jams_before_stop) begin
          cmd_trig = 16'sd0;
          state_nxt.mode = fjg_pkg::MODE_STOPPED;
          state_nxt.stall_timing = 1'b0;
          state_nxt.jam_count = 4'd0;
        end else begin
          cmd_trig = cfg.backoff_speed;
          state_nxt.mode = fjg_pkg::MODE_REVERSING;
          state_nxt.jam_count = cnt_inc;
        end
      end
      fjg_pkg::MODE_REVERSING: begin
        if (phase_elapsed >= {16'd0, cfg.reverse_ms}) begin
          state_nxt.mode = fjg_pkg::MODE_NORMAL;
          sent = 1'b1;
          cmd_trig = trig;
        end
      end
      default: begin
        sent = 1'b1;
        if (phase_elapsed >= {16'd0, cfg.stop_ms}) begin
          state_nxt.mode = fjg_pkg::MODE_NORMAL;
          cmd_trig = trig;
        end else begin
          cmd_trig = 16'sd0;
        end
      end
    endcase
    if (sent) begin
      state_nxt.last_friction_command = item.friction_target;
      state_nxt.last_trigger_command = cmd_trig;
    end
  end

  assign result.command_sent = sent;
  assign result.friction_command = state_nxt.last_friction_command;
  assign result.trigger_command = state_nxt.last_trigger_command;
  assign result.jam_mode = state_nxt.mode;
  assign result.fire_inhibited = locked;

endmodule

FILE: sv/feeder_jam_guard_heat_lock.sv
// feeder_jam_guard_heat_lock: top level, input register, state, result register.
// Depends on fjg_pkg and fjg_step.
//
// Feeder jam guard with heat lock. Each input word is one control step (tick,
// heat, heat limit, friction and feeder targets, measured feeder speed); each
// step gives exactly one result word with the speed commands, the jam mode
// after the step and the heat-lock flag. The block takes one word per clock
// when the result side keeps up; a result word is registered: each accepted
// input word passes the input register, then the step logic into the result
// register. The step state lives in flip-flops and is updated in the same
// edge that loads the result register, so back-to-back words see the state
// of their predecessor. Configuration writes are always accepted
// (cfg_ready is tied high) and should only be issued while the block is idle.
module feeder_jam_guard_heat_lock (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [31:0]                      in_now_ms,
  input  logic [15:0]                      in_heat,
  input  logic [15:0]                      in_heat_limit,
  input  logic signed [15:0]               in_friction_target,
  input  logic signed [15:0]               in_trigger_target,
  input  logic signed [15:0]               in_trigger_measured,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_command_sent,
  output logic signed [15:0]               out_friction_command,
  output logic signed [15:0]               out_trigger_command,
  output logic [1:0]                       out_jam_mode,
  output logic                             out_fire_inhibited,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fjg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fjg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  fjg_pkg::fjg_cfg_t    cfg_r;
  fjg_pkg::fjg_state_t  state_r;
  fjg_pkg::fjg_state_t  state_nxt;
  fjg_pkg::fjg_item_t   item_r;
  fjg_pkg::fjg_result_t step_res;
  fjg_pkg::fjg_result_t res_r;
  logic                 item_vld_r;
  logic                 res_vld_r;
  logic                 advance;
  logic                 in_accept;

  // the result register frees up when empty or being drained this cycle
  assign advance   = item_vld_r && (!res_vld_r || !out_stall);
  assign in_stall  = item_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lock_margin      <= 16'd30;
      cfg_r.resume_heat      <= 16'd40;
      cfg_r.speed_tolerance  <= 15'd500;
      cfg_r.jam_timeout_ms   <= 16'd500;
      cfg_r.jams_before_stop <= 4'd3;
      cfg_r.backoff_speed    <= -16'sd1000;
      cfg_r.reverse_ms       <= 16'd200;
      cfg_r.stop_ms          <= 16'd3000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fjg_pkg::CFG_LOCK_MARGIN:      cfg_r.lock_margin      <= cfg_data;
        fjg_pkg::CFG_RESUME_HEAT:      cfg_r.resume_heat      <= cfg_data;
        fjg_pkg::CFG_SPEED_TOLERANCE:  cfg_r.speed_tolerance  <= cfg_data[14:0];
        fjg_pkg::CFG_JAM_TIMEOUT_MS:   cfg_r.jam_timeout_ms   <= cfg_data;
        fjg_pkg::CFG_JAMS_BEFORE_STOP: cfg_r.jams_before_stop <= cfg_data[3:0];
        fjg_pkg::CFG_BACKOFF_SPEED:    cfg_r.backoff_speed    <= $signed(cfg_data);
        fjg_pkg::CFG_REVERSE_MS:       cfg_r.reverse_ms       <= cfg_data;
        fjg_pkg::CFG_STOP_MS:          cfg_r.stop_ms          <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.now_ms           <= in_now_ms;
      item_r.heat             <= in_heat;
      item_r.heat_limit       <= in_heat_limit;
      item_r.friction_target  <= in_friction_target;
      item_r.trigger_target   <= in_trigger_target;
      item_r.trigger_measured <= in_trigger_measured;
    end
  end

  // valid flags of both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_accept) item_vld_r <= 1'b1;
      else if (advance) item_vld_r <= 1'b0;
      if (advance) res_vld_r <= 1'b1;
      else if (!out_stall) res_vld_r <= 1'b0;
    end
  end

  fjg_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // step state commits together with the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.heat_locked           <= 1'b0;
      state_r.mode                  <= fjg_pkg::MODE_NORMAL;
      state_r.stall_timing          <= 1'b0;
      state_r.stall_start           <= 32'd0;
      state_r.jam_count             <= 4'd0;
      state_r.phase_start           <= 32'd0;
      state_r.last_trigger_command  <= 16'sd0;
      state_r.last_friction_command <= 16'sd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= step_res;
  end

  assign out_valid            = res_vld_r;
  assign out_command_sent     = res_r.command_sent;
  assign out_friction_command = res_r.friction_command;
  assign out_trigger_command  = res_r.trigger_command;
  assign out_jam_mode         = res_r.jam_mode;
  assign out_fire_inhibited   = res_r.fire_inhibited;

endmodule

FILE: sv/fjg_checker.sv
// fjg_checker: port-level assertions for feeder_jam_guard_heat_lock, with bind.
// Depends on fjg_pkg for the mode codes.
module fjg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_command_sent,
  input logic signed [15:0] out_friction_command,
  input logic signed [15:0] out_trigger_command,
  input logic [1:0]         out_jam_mode,
  input logic               out_fire_inhibited
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_trigger_command)
      && $stable(out_friction_command) && $stable(out_jam_mode))
    else $error("stalled result word changed");

  // the only step without a command is a reversal still running
  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_command_sent |-> out_jam_mode == fjg_pkg::MODE_REVERSING)
    else $error("no command outside reversal");

  // entering blocked always comes from normal, which issues a command
  a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_jam_mode == fjg_pkg::MODE_BLOCKED |-> out_command_sent)
    else $error("blocked step without command");

  // under heat lock, a normal-mode command never feeds
  a_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fire_inhibited && out_jam_mode == fjg_pkg::MODE_NORMAL
      |-> out_trigger_command == 16'sd0)
    else $error("feeder driven while heat locked");

  // results start empty after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind feeder_jam_guard_heat_lock fjg_checker u_fjg_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_command_sent     (out_command_sent),
  .out_friction_command (out_friction_command),
  .out_trigger_command  (out_trigger_command),
  .out_jam_mode         (out_jam_mode),
  .out_fire_inhibited   (out_fire_inhibited)
);
